// ===== rtl/mpi_pkg.sv =====
// shared types and constants for the mandelbrot point iterator
// used by mpi_ctrl, mpi_datapath and the top level; no dependencies
`default_nettype none

package mpi_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT   = 27;

   localparam int COUNT_WIDTH     = 24;
   localparam int ITER_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [ITER_WIDTH-1:0] MAX_ITERATIONS_RESET = 16'd1024;
   localparam logic                  CARDIOID_ENABLE_RESET = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_ITERATIONS  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CARDIOID_ENABLE = 1'd1;

   typedef enum logic [1:0] {
      UPDATE_NONE    = 2'd0,
      UPDATE_STORE_Z = 2'd1,
      UPDATE_ESCAPED = 2'd2
   } update_kind_type;

   // how a point ended
   typedef enum logic [1:0] {
      OUT_SKIP    = 2'd0,
      OUT_REGION  = 2'd1,
      OUT_BOUNDED = 2'd2,
      OUT_ESCAPE  = 2'd3
   } outcome_type;

   // operand sets for the three multipliers
   typedef enum logic [1:0] {
      MUL_ITER  = 2'd0,
      MUL_CARD1 = 2'd1,
      MUL_CARD2 = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        card_sum;
      logic        card_dsum;
      logic        step;
      logic        load_rsp;
      outcome_type outcome;
   } cmd_type;

   typedef struct packed {
      logic escaped_in;
      logic card_go;
      logic escape;
      logic last_step;
      logic in_region;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/mpi_ctrl.sv =====
// sequencer for the mandelbrot point iterator: handshakes and step order
// depends on mpi_pkg; drives mpi_datapath through cmd_type, reads status_type
`default_nettype none

module mpi_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output mpi_pkg::cmd_type    cmd,
   input  mpi_pkg::status_type status
);
   import mpi_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_CHECK     = 9'b000000010,
      ST_CARD_SUM  = 9'b000000100,
      ST_CARD_DSUM = 9'b000001000,
      ST_CARD_MUL2 = 9'b000010000,
      ST_CARD_CMP  = 9'b000100000,
      ST_ITER_MUL  = 9'b001000000,
      ST_ITER_UPD  = 9'b010000000,
      ST_FINISH    = 9'b100000000
   } state_type;

   state_type   state_ff, state_in;
   outcome_type outcome_ff, outcome_in;
   logic        rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      outcome_in    = outcome_ff;
      cmd.load      = 1'b0;
      cmd.mul_en    = 1'b0;
      cmd.mul_sel   = MUL_ITER;
      cmd.card_sum  = 1'b0;
      cmd.card_dsum = 1'b0;
      cmd.step      = 1'b0;
      cmd.load_rsp  = 1'b0;
      cmd.outcome   = outcome_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // cardioid products start here whether or not they are needed
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_CARD1;
            if (status.escaped_in) begin
               outcome_in = OUT_SKIP;
               state_in   = ST_FINISH;
            end else if (status.card_go) begin
               state_in = ST_CARD_SUM;
            end else begin
               state_in = ST_ITER_MUL;
            end
         end
         ST_CARD_SUM: begin
            cmd.card_sum = 1'b1;
            state_in     = ST_CARD_DSUM;
         end
         ST_CARD_DSUM: begin
            cmd.card_dsum = 1'b1;
            state_in      = ST_CARD_MUL2;
         end
         ST_CARD_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_CARD2;
            state_in    = ST_CARD_CMP;
         end
         ST_CARD_CMP: begin
            if (status.in_region) begin
               outcome_in = OUT_REGION;
               state_in   = ST_FINISH;
            end else begin
               state_in = ST_ITER_MUL;
            end
         end
         ST_ITER_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ITER;
            state_in    = ST_ITER_UPD;
         end
         ST_ITER_UPD: begin
            // escape test comes before the step
            if (status.escape) begin
               outcome_in = OUT_ESCAPE;
               state_in   = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
               if (status.last_step) begin
                  outcome_in = OUT_BOUNDED;
                  state_in   = ST_FINISH;
               end else begin
                  state_in = ST_ITER_MUL;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         outcome_ff   <= OUT_SKIP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         outcome_ff   <= outcome_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mpi_datapath.sv =====
// datapath of the mandelbrot point iterator: operand registers, three multipliers,
// saturating fixed point arithmetic, settings registers and result register; uses mpi_pkg
`default_nettype none

module mpi_datapath #(
   parameter int VALUE_WIDTH = mpi_pkg::VALUE_WIDTH_DEFAULT,
   parameter int FRAC_BITS   = mpi_pkg::FRAC_BITS_DEFAULT,
   localparam int REQ_DATA_WIDTH = ((4*VALUE_WIDTH + mpi_pkg::COUNT_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_WIDTH = ((2*VALUE_WIDTH + mpi_pkg::COUNT_WIDTH + 7) / 8) * 8
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire  [REQ_DATA_WIDTH-1:0]            req_tdata,
   input  wire                                  req_tuser,
   input  wire                                  csr_wen,
   input  wire  [mpi_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire  [mpi_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   input  mpi_pkg::cmd_type                     cmd,
   output mpi_pkg::status_type                  status,
   output logic [RSP_DATA_WIDTH-1:0]            rsp_tdata,
   output logic [2:0]                           rsp_tuser
);
   import mpi_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int PW = 2 * VALUE_WIDTH;

   localparam logic signed [W-1:0]  VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0]  VMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [PW-1:0] VMAX_WIDE = {{(W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [PW-1:0] VMIN_WIDE = {{(W+1){1'b1}}, {(W-1){1'b0}}};

   localparam logic signed [W-1:0] FX_ONE         = W'(64'd1 << FRAC_BITS);
   localparam logic signed [W-1:0] FX_TWO         = W'(64'd1 << (FRAC_BITS + 1));
   localparam logic signed [W-1:0] FX_NEG_TWO     = -FX_TWO;
   localparam logic signed [W-1:0] FX_QUARTER     = W'(64'd1 << (FRAC_BITS - 2));
   localparam logic signed [W-1:0] FX_NEG_QUARTER = -FX_QUARTER;
   localparam logic signed [W-1:0] FX_SIXTEENTH   = W'(64'd1 << (FRAC_BITS - 4));
   localparam logic [W:0]          FX_FOUR        = (W+1)'(65'd1 << (FRAC_BITS + 2));

   // exact product, floor shift, clamp to the value range
   function automatic logic signed [W-1:0] sat_shift(input logic signed [PW-1:0] p,
                                                     input int s);
      logic signed [PW-1:0] q;
      q = p >>> s;
      if (q > VMAX_WIDE) begin
         return VMAX;
      end else if (q < VMIN_WIDE) begin
         return VMIN;
      end
      return q[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] add_sat(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) begin
         return s[W] ? VMIN : VMAX;
      end
      return s[W-1:0];
   endfunction

   // request fields
   logic signed [W-1:0]     in_c_re, in_c_im, in_z_re, in_z_im;
   logic [COUNT_WIDTH-1:0]  in_prior;

   assign in_c_re  = req_tdata[0*W +: W];
   assign in_c_im  = req_tdata[1*W +: W];
   assign in_z_re  = req_tdata[2*W +: W];
   assign in_z_im  = req_tdata[3*W +: W];
   assign in_prior = req_tdata[4*W +: COUNT_WIDTH];

   // settings
   logic [ITER_WIDTH-1:0] max_iter_ff, max_iter_in;
   logic                  card_en_ff, card_en_in;

   always_comb begin
      max_iter_in = max_iter_ff;
      card_en_in  = card_en_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_MAX_ITERATIONS:  max_iter_in = csr_wdata[ITER_WIDTH-1:0];
            REG_CARDIOID_ENABLE: card_en_in  = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITERATIONS_RESET;
         card_en_ff  <= CARDIOID_ENABLE_RESET;
      end else begin
         max_iter_ff <= max_iter_in;
         card_en_ff  <= card_en_in;
      end
   end

   // point registers
   logic signed [W-1:0]    cr_ff, ci_ff, x_ff, y_ff, roff_q_ff, roff_one_ff;
   logic signed [W-1:0]    x_in, y_in;
   logic [COUNT_WIDTH-1:0] prior_ff;
   logic                   escaped_ff, in_range_ff;
   logic [ITER_WIDTH-1:0]  t_ff, t_in;

   // product registers and cardioid temporaries
   logic signed [PW-1:0]   pa_ff, pb_ff, pc_ff, pa_in, pb_in, pc_in;
   logic signed [W-1:0]    ma_a, ma_b, mb_a, mb_b, mc_a, mc_b;
   logic signed [W-1:0]    isq_ff, dist_ff, dsum_ff;
   logic                   bulb_ff;

   // iteration terms from the product registers
   logic signed [W-1:0]    sq_a, sq_b, sq_c, xy2;
   logic [W:0]             mag_sum;

   assign sq_a    = sat_shift(pa_ff, FRAC_BITS);
   assign sq_b    = sat_shift(pb_ff, FRAC_BITS);
   assign sq_c    = sat_shift(pc_ff, FRAC_BITS);
   assign xy2     = sat_shift(pc_ff, FRAC_BITS - 1);
   assign mag_sum = {1'b0, sq_a} + {1'b0, sq_b};

   always_comb begin
      case (cmd.mul_sel)
         MUL_CARD1: begin
            ma_a = ci_ff;      ma_b = ci_ff;
            mb_a = roff_q_ff;  mb_b = roff_q_ff;
            mc_a = roff_one_ff; mc_b = roff_one_ff;
         end
         MUL_CARD2: begin
            ma_a = dist_ff;    ma_b = dsum_ff;
            mb_a = y_ff;       mb_b = y_ff;
            mc_a = x_ff;       mc_b = y_ff;
         end
         default: begin
            ma_a = x_ff;       ma_b = x_ff;
            mb_a = y_ff;       mb_b = y_ff;
            mc_a = x_ff;       mc_b = y_ff;
         end
      endcase
      pa_in = PW'(ma_a) * PW'(ma_b);
      pb_in = PW'(mb_a) * PW'(mb_b);
      pc_in = PW'(mc_a) * PW'(mc_b);
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      t_in = t_ff;
      if (cmd.load) begin
         x_in = in_z_re;
         y_in = in_z_im;
         t_in = '0;
      end else if (cmd.step) begin
         x_in = add_sat(sq_a - sq_b, cr_ff);
         y_in = add_sat(xy2, ci_ff);
         t_in = t_ff + ITER_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      t_ff <= t_in;
      if (cmd.load) begin
         cr_ff       <= in_c_re;
         ci_ff       <= in_c_im;
         prior_ff    <= in_prior;
         escaped_ff  <= req_tuser;
         roff_q_ff   <= add_sat(in_c_re, FX_NEG_QUARTER);
         roff_one_ff <= add_sat(in_c_re, FX_ONE);
         in_range_ff <= (in_c_re < FX_TWO) && (in_c_re > FX_NEG_TWO) &&
                        (in_c_im < FX_TWO) && (in_c_im > FX_NEG_TWO);
      end
      if (cmd.mul_en) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         pc_ff <= pc_in;
      end
      if (cmd.card_sum) begin
         isq_ff  <= sq_a;
         dist_ff <= add_sat(sq_b, sq_a);
         bulb_ff <= add_sat(sq_c, sq_a) < FX_SIXTEENTH;
      end
      if (cmd.card_dsum) begin
         dsum_ff <= add_sat(dist_ff, roff_q_ff);
      end
   end

   // status
   logic [ITER_WIDTH-1:0] limit_m1;

   // a limit of zero runs one step
   assign limit_m1 = (max_iter_ff == '0) ? '0 : max_iter_ff - ITER_WIDTH'(1);

   assign status.escaped_in = escaped_ff;
   assign status.card_go    = card_en_ff && in_range_ff;
   assign status.escape     = mag_sum >= FX_FOUR;
   assign status.last_step  = (t_ff == limit_m1);
   // quarter of a nonnegative square is a right shift, rounded down
   assign status.in_region  = (sq_a < (isq_ff >>> 2)) || bulb_ff;

   // result register
   logic                   in_set_ff;
   update_kind_type        kind_ff;
   logic signed [W-1:0]    zr_ff, zi_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH:0]   total;
   logic [COUNT_WIDTH-1:0] total_sat;

   assign total     = {1'b0, prior_ff} + (COUNT_WIDTH+1)'(t_ff);
   assign total_sat = total[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : total[COUNT_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         zr_ff    <= '0;
         zi_ff    <= '0;
         count_ff <= '0;
         case (cmd.outcome)
            OUT_SKIP: begin
               in_set_ff <= 1'b0;
               kind_ff   <= UPDATE_NONE;
            end
            OUT_REGION: begin
               in_set_ff <= 1'b1;
               kind_ff   <= UPDATE_NONE;
            end
            OUT_BOUNDED: begin
               in_set_ff <= 1'b1;
               kind_ff   <= UPDATE_STORE_Z;
               zr_ff     <= x_ff;
               zi_ff     <= y_ff;
            end
            default: begin
               in_set_ff <= 1'b0;
               kind_ff   <= UPDATE_ESCAPED;
               count_ff  <= total_sat;
            end
         endcase
      end
   end

   assign rsp_tdata = RSP_DATA_WIDTH'({count_ff, zi_ff, zr_ff});
   assign rsp_tuser = {kind_ff, in_set_ff};

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_point_iterator.sv =====
// top level of the mandelbrot point iterator: escape-time steps on one point
// depends on mpi_pkg, mpi_ctrl and mpi_datapath
//
//   channel  dir  beat contents
//   req      in   tdata: c_re, c_im, z_re, z_im, prior_iterations  tuser: already_escaped
//   rsp      out  tdata: new_z_re, new_z_im, iteration_count  tuser: in_set, update_kind
//   csr      in   csr_wen, csr_index (0 max_iterations, 1 cardioid_enable), csr_wdata
//
// one point at a time; the z*z+c loop is the limit, each step a multiply state
// (three multipliers), then an update state (saturate, escape compare and update)
// the cardioid test adds the card_sum, card_dsum, card_mul2 and card_cmp states;
// an already escaped point goes from the check state straight to finish
// synchronous active high reset; settings return to 1024 and cardioid test on
// a waiting result holds only the last cycle of the next point

`default_nettype none

module mandelbrot_point_iterator #(
   parameter int VALUE_WIDTH = mpi_pkg::VALUE_WIDTH_DEFAULT,
   parameter int FRAC_BITS   = mpi_pkg::FRAC_BITS_DEFAULT,
   localparam int REQ_DATA_WIDTH = ((4*VALUE_WIDTH + mpi_pkg::COUNT_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_WIDTH = ((2*VALUE_WIDTH + mpi_pkg::COUNT_WIDTH + 7) / 8) * 8
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // c_re, c_im, z_re, z_im, prior_iterations
   input  wire  [REQ_DATA_WIDTH-1:0]            req_tdata,
   // already_escaped
   input  wire                                  req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // new_z_re, new_z_im, iteration_count
   output logic [RSP_DATA_WIDTH-1:0]            rsp_tdata,
   // in_set, update_kind
   output logic [2:0]                           rsp_tuser,
   input  wire                                  csr_wen,
   input  wire  [mpi_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire  [mpi_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import mpi_pkg::*;

   cmd_type    cmd;
   status_type status;

   mpi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   mpi_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire
